### sv/mrfo_pkg.sv
// Shared types and constants of the message ring FIFO.
package mrfo_pkg;

   localparam int NUM_SLOTS_DEF   = 16;
   localparam int MAX_MSG_LEN_DEF = 64;
   localparam int OPQ_DEPTH       = 2;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;

   // Classified command travelling from the front to the back
   typedef struct packed {
      logic       is_pop;
      logic       too_long;
      logic       zero_len;
      logic [7:0] msg_type;
      logic [7:0] msg_length;
      logic [7:0] data_byte;
      logic       byte_last;
   } op_type;

   // One result item
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] out_type;
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
   } rsp_type;

endpackage

### sv/mrfo_ifs.sv
// Channel interfaces of the message ring FIFO: command items in, result items out.
interface mrfo_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] msg_type;
   logic [7:0] msg_length;
   logic [7:0] data_byte;
   logic       byte_last;

   modport source (output valid, command, msg_type, msg_length, data_byte, byte_last,
                   input ready);
   modport sink   (input valid, command, msg_type, msg_length, data_byte, byte_last,
                   output ready);
endinterface

interface mrfo_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] out_type;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       last;

   modport source (output valid, status, out_type, out_byte, byte_valid, last,
                   input ready);
   modport sink   (input valid, status, out_type, out_byte, byte_valid, last,
                   output ready);
endinterface

### sv/mrfo_front.sv
// Front end: accept command items, classify them and hold one in a register stage.
module mrfo_front #(
   parameter int MAX_MSG_LEN = mrfo_pkg::MAX_MSG_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   mrfo_req_if.sink             req,
   output logic                 op_valid,
   input  logic                 op_ready,
   output mrfo_pkg::op_type     op
);

   logic             valid_ff;
   mrfo_pkg::op_type op_ff;
   mrfo_pkg::op_type op_in;
   logic             take;

   assign req.ready = !valid_ff || op_ready;
   assign take      = req.valid && req.ready;
   assign op_valid  = valid_ff;
   assign op        = op_ff;

   always_comb begin
      op_in.is_pop     = (req.command == mrfo_pkg::CMD_POP);
      op_in.too_long   = (req.msg_length > 8'(MAX_MSG_LEN));
      op_in.zero_len   = (req.msg_length == 8'd0);
      op_in.msg_type   = req.msg_type;
      op_in.msg_length = req.msg_length;
      op_in.data_byte  = req.data_byte;
      op_in.byte_last  = req.byte_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (op_ready) begin
         valid_ff <= 1'b0;
      end
      if (take) begin
         op_ff <= op_in;
      end
   end

endmodule

### sv/mrfo_op_queue.sv
// Short queue of classified commands between front and back.
module mrfo_op_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mrfo_pkg::op_type in_op,
   output logic             out_valid,
   input  logic             out_ready,
   output mrfo_pkg::op_type out_op
);

   localparam int DEPTH = mrfo_pkg::OPQ_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mrfo_pkg::op_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_op    = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_op;
      end
   end

endmodule

### sv/mrfo_back.sv
// Back end: message slots, ring pointers, copy sweep and the result register.
module mrfo_back #(
   parameter int NUM_SLOTS   = mrfo_pkg::NUM_SLOTS_DEF,
   parameter int MAX_MSG_LEN = mrfo_pkg::MAX_MSG_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   output logic             op_ready,
   input  mrfo_pkg::op_type op,
   mrfo_rsp_if.source       rsp
);

   localparam int PW     = $clog2(NUM_SLOTS);
   localparam int LW     = $clog2(MAX_MSG_LEN + 1);
   localparam int IW     = (MAX_MSG_LEN > 1) ? $clog2(MAX_MSG_LEN) : 1;
   localparam int STRIDE = 2 ** IW;
   localparam int DEPTH  = NUM_SLOTS * STRIDE;
   localparam int AW     = PW + IW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COPY,
      S_FIN,
      S_DESC,
      S_STREAM
   } state_type;

   state_type         state_ff,      state_in;
   logic [PW-1:0]     wp_ff,         wp_in;
   logic [PW-1:0]     rp_ff,         rp_in;
   logic [LW-1:0]     bc_ff,         bc_in;
   logic [LW-1:0]     decl_ff,       decl_in;
   logic [7:0]        stage_type_ff, stage_type_in;
   logic [7:0]        pop_type_ff,   pop_type_in;
   logic [LW-1:0]     cnt_len_ff,    cnt_len_in;
   logic [LW-1:0]     idx_ff,        idx_in;
   logic [IW-1:0]     widx_ff,       widx_in;
   logic              rd_pend_ff,    rd_pend_in;
   logic              rd_last_ff,    rd_last_in;
   logic [PW-1:0]     rd_slot_ff,    rd_slot_in;
   logic [PW-1:0]     dst_slot_ff,   dst_slot_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   mrfo_pkg::rsp_type rsp_ff,        rsp_in;

   // payload and descriptor memories
   logic [7:0]    pay_mem [DEPTH];
   logic [7:0]    pay_rd_ff;
   logic [7:0]    dtype_mem [NUM_SLOTS];
   logic [LW-1:0] dlen_mem [NUM_SLOTS];
   logic [7:0]    dtype_rd_ff;
   logic [LW-1:0] dlen_rd_ff;

   logic          pay_we, pay_re;
   logic [AW-1:0] pay_wa, pay_ra;
   logic [7:0]    pay_wd;
   logic          desc_we, desc_re;
   logic [PW-1:0] desc_wa;
   logic [7:0]    desc_wt;
   logic [LW-1:0] desc_wl;

   logic          out_free;
   logic          first_v;
   logic [7:0]    type_v;
   logic [LW-1:0] decl_v;
   logic [LW-1:0] bc_inc;
   logic          commit_v;
   logic [LW-1:0] clen_v;
   logic          consume;
   logic [PW-1:0] wp_next, wp_prev, rp_next;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign wp_next  = (wp_ff == PW'(NUM_SLOTS - 1)) ? '0 : wp_ff + PW'(1);
   assign wp_prev  = (wp_ff == '0) ? PW'(NUM_SLOTS - 1) : wp_ff - PW'(1);
   assign rp_next  = (rp_ff == PW'(NUM_SLOTS - 1)) ? '0 : rp_ff + PW'(1);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_ff.status;
   assign rsp.out_type   = rsp_ff.out_type;
   assign rsp.out_byte   = rsp_ff.out_byte;
   assign rsp.byte_valid = rsp_ff.byte_valid;
   assign rsp.last       = rsp_ff.last;

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      bc_in         = bc_ff;
      decl_in       = decl_ff;
      stage_type_in = stage_type_ff;
      pop_type_in   = pop_type_ff;
      cnt_len_in    = cnt_len_ff;
      idx_in        = idx_ff;
      widx_in       = widx_ff;
      rd_pend_in    = rd_pend_ff;
      rd_last_in    = rd_last_ff;
      rd_slot_in    = rd_slot_ff;
      dst_slot_in   = dst_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_in        = rsp_ff;
      op_ready      = 1'b0;
      pay_we        = 1'b0;
      pay_wa        = '0;
      pay_wd        = '0;
      pay_re        = 1'b0;
      pay_ra        = '0;
      desc_we       = 1'b0;
      desc_wa       = '0;
      desc_wt       = '0;
      desc_wl       = '0;
      desc_re       = 1'b0;
      first_v       = (bc_ff == '0);
      type_v        = first_v ? op.msg_type : stage_type_ff;
      decl_v        = first_v ? op.msg_length[LW-1:0] : decl_ff;
      bc_inc        = bc_ff + LW'(1);
      commit_v      = 1'b0;
      clen_v        = '0;
      consume       = rd_pend_ff && out_free;

      unique case (state_ff)
         S_IDLE: begin
            if (op_valid && out_free) begin
               op_ready = 1'b1;
               if (op.is_pop) begin
                  if (rp_ff == wp_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{status: mrfo_pkg::STATUS_EMPTY, out_type: 8'd0,
                                out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1};
                  end else begin
                     // fetch the oldest descriptor and free its slot
                     desc_re    = 1'b1;
                     rd_slot_in = rp_ff;
                     rp_in      = rp_next;
                     state_in   = S_DESC;
                  end
               end else if (first_v && op.too_long) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: mrfo_pkg::STATUS_TOO_LONG, out_type: 8'd0,
                             out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1};
               end else begin
                  stage_type_in = type_v;
                  decl_in       = decl_v;
                  if (first_v && op.zero_len) begin
                     commit_v = 1'b1;
                  end else begin
                     pay_we = 1'b1;
                     pay_wa = {wp_ff, bc_ff[IW-1:0]};
                     pay_wd = op.data_byte;
                     bc_in  = bc_inc;
                     if (op.byte_last || (bc_inc >= decl_v)) begin
                        commit_v = 1'b1;
                        clen_v   = bc_inc;
                     end
                  end
                  if (commit_v) begin
                     bc_in   = '0;
                     desc_we = 1'b1;
                     desc_wt = type_v;
                     desc_wl = clen_v;
                     if (wp_next != rp_ff) begin
                        desc_wa      = wp_ff;
                        wp_in        = wp_next;
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: mrfo_pkg::STATUS_OK, out_type: 8'd0,
                                   out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1};
                     end else begin
                        // ring full: replace the newest message in place
                        desc_wa     = wp_prev;
                        dst_slot_in = wp_prev;
                        rd_slot_in  = wp_ff;
                        cnt_len_in  = clen_v;
                        idx_in      = '0;
                        rd_pend_in  = 1'b0;
                        state_in    = S_COPY;
                     end
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{status: mrfo_pkg::STATUS_OK, out_type: 8'd0,
                                out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1};
                  end
               end
            end
         end

         S_COPY: begin
            if (rd_pend_ff) begin
               pay_we = 1'b1;
               pay_wa = {dst_slot_ff, widx_ff};
               pay_wd = pay_rd_ff;
            end
            if (idx_ff < cnt_len_ff) begin
               pay_re     = 1'b1;
               pay_ra     = {rd_slot_ff, idx_ff[IW-1:0]};
               widx_in    = idx_ff[IW-1:0];
               idx_in     = idx_ff + LW'(1);
               rd_pend_in = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
               if (!rd_pend_ff) begin
                  state_in = S_FIN;
               end
            end
         end

         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: mrfo_pkg::STATUS_OK, out_type: 8'd0,
                          out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1};
               state_in = S_IDLE;
            end
         end

         S_DESC: begin
            pop_type_in = dtype_rd_ff;
            cnt_len_in  = dlen_rd_ff;
            idx_in      = '0;
            rd_pend_in  = 1'b0;
            if (dlen_rd_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: mrfo_pkg::STATUS_OK, out_type: dtype_rd_ff,
                             out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1};
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_STREAM;
            end
         end

         S_STREAM: begin
            if (consume) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: mrfo_pkg::STATUS_OK, out_type: pop_type_ff,
                          out_byte: pay_rd_ff, byte_valid: 1'b1, last: rd_last_ff};
            end
            if (!rd_pend_ff || consume) begin
               if (idx_ff < cnt_len_ff) begin
                  pay_re     = 1'b1;
                  pay_ra     = {rd_slot_ff, idx_ff[IW-1:0]};
                  idx_in     = idx_ff + LW'(1);
                  rd_pend_in = 1'b1;
                  rd_last_in = ((idx_ff + LW'(1)) == cnt_len_ff);
               end else begin
                  rd_pend_in = 1'b0;
                  state_in   = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         bc_ff        <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         bc_ff        <= bc_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      decl_ff       <= decl_in;
      stage_type_ff <= stage_type_in;
      pop_type_ff   <= pop_type_in;
      cnt_len_ff    <= cnt_len_in;
      idx_ff        <= idx_in;
      widx_ff       <= widx_in;
      rd_last_ff    <= rd_last_in;
      rd_slot_ff    <= rd_slot_in;
      dst_slot_ff   <= dst_slot_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[pay_wa] <= pay_wd;
      end
      if (pay_re) begin
         pay_rd_ff <= pay_mem[pay_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (desc_we) begin
         dtype_mem[desc_wa] <= desc_wt;
         dlen_mem[desc_wa]  <= desc_wl;
      end
      if (desc_re) begin
         dtype_rd_ff <= dtype_mem[rp_ff];
         dlen_rd_ff  <= dlen_mem[rp_ff];
      end
   end

endmodule

### sv/message_ring_fifo_overwrite_newest_unit.sv
// Top level of the message ring FIFO that overwrites its newest message when full.
//
// A ring of NUM_SLOTS message slots, each with a type byte, a length and up to
// MAX_MSG_LEN payload bytes; one slot always stays free for staging. Push items
// deliver a message one byte per item and each returns one status item; a pop
// returns the oldest message one byte per item (last marks the final byte), one
// status item with the type for an empty message, or an empty status. Items pass
// a front register and a two-entry command queue, so the input keeps flowing
// while the back end works or the result side stalls, until the queue fills. A
// push that completes a message into a full ring copies the finished bytes over
// the newest stored message through the single payload memory port pair. A pop
// reads the descriptor, then issues the first payload read, then streams one
// byte per cycle while the result side accepts; the payload memory read is
// registered. The stores need no clearing after reset: an entry is only ever
// read once written.
module message_ring_fifo_overwrite_newest_unit #(
   parameter int NUM_SLOTS   = mrfo_pkg::NUM_SLOTS_DEF,
   parameter int MAX_MSG_LEN = mrfo_pkg::MAX_MSG_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mrfo_req_if.sink   req_chan,
   mrfo_rsp_if.source rsp_chan
);

   // front to queue
   logic             fr_valid;
   logic             fr_ready;
   mrfo_pkg::op_type fr_op;

   // queue to back
   logic             bk_valid;
   logic             bk_ready;
   mrfo_pkg::op_type bk_op;

   // accept and classify: pop or push, over-length declaration, zero length
   mrfo_front #(
      .MAX_MSG_LEN (MAX_MSG_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .op_valid (fr_valid),
      .op_ready (fr_ready),
      .op       (fr_op)
   );

   // decouple the front from the back end
   mrfo_op_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_op     (fr_op),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_op    (bk_op)
   );

   // carry out pushes and pops against the slot memories
   mrfo_back #(
      .NUM_SLOTS   (NUM_SLOTS),
      .MAX_MSG_LEN (MAX_MSG_LEN)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (bk_valid),
      .op_ready (bk_ready),
      .op       (bk_op),
      .rsp      (rsp_chan)
   );

endmodule
